// ===== design/sol_pkg.sv =====
// package for the solitaire keystream block: deck constants, reset order, op codes
// no dependencies
`default_nettype none
package sol_pkg;
    localparam int CARD_W = 5;
    localparam int IDX_W = 5;
    localparam int NUM_LETTERS = 26;
    localparam logic [CARD_W-1:0] JOKER_A = 5'd27;
    localparam logic [CARD_W-1:0] JOKER_B = 5'd28;
    localparam int STEP_LIMIT = 128;
    localparam int STEP_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    function automatic logic [CARD_W-1:0] reset_card(input logic [IDX_W-1:0] idx);
        logic [CARD_W-1:0] v;
        case (idx)
            5'd0: v = 5'd1;   5'd1: v = 5'd4;   5'd2: v = 5'd7;   5'd3: v = 5'd10;
            5'd4: v = 5'd13;  5'd5: v = 5'd16;  5'd6: v = 5'd19;  5'd7: v = 5'd22;
            5'd8: v = 5'd25;  5'd9: v = 5'd28;  5'd10: v = 5'd3;  5'd11: v = 5'd6;
            5'd12: v = 5'd9;  5'd13: v = 5'd12; 5'd14: v = 5'd15; 5'd15: v = 5'd18;
            5'd16: v = 5'd21; 5'd17: v = 5'd24; 5'd18: v = 5'd27; 5'd19: v = 5'd2;
            5'd20: v = 5'd5;  5'd21: v = 5'd8;  5'd22: v = 5'd11; 5'd23: v = 5'd14;
            5'd24: v = 5'd17; 5'd25: v = 5'd20; 5'd26: v = 5'd23; 5'd27: v = 5'd26;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    function automatic logic [CARD_W-1:0] card_count(input logic [CARD_W-1:0] v);
        return (v > 5'd27) ? 5'd27 : v;
    endfunction
endpackage
`default_nettype wire

// ===== design/sol_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module sol_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 28
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/sol_keystep.sv =====
// keystream sequencer: runs the solitaire steps over two deck memories
// depends on sol_pkg and sol_ram
`default_nettype none
module sol_keystep import sol_pkg::*; #(
    parameter int N = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_load,
    input  wire logic [IDX_W-1:0]  i_load_pos,
    input  wire logic [CARD_W-1:0] i_load_card,
    output logic                   o_busy,
    output logic                   o_done,
    output logic                   o_found,
    output logic [CARD_W-1:0]      o_key
);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

    // every copy pass copies the deck from one bank to the other under a permutation;
    // the destination index of each source index is computed from a few scalars
    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SCANA = 11'b00000000100,
        S_MOVA  = 11'b00000001000,
        S_SCANB = 11'b00000010000,
        S_MOVB  = 11'b00000100000,
        S_SCANJ = 11'b00001000000,
        S_TCUT  = 11'b00010000000,
        S_BOT   = 11'b00100000000,
        S_CCUT  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic r_bank, n_bank;               // bank that holds the live deck
    logic [IDX_W:0] r_cnt, n_cnt;       // sweep counter, runs past the last index to cover the registered read
    logic [IDX_W-1:0] r_pa, n_pa, r_pb, n_pb, r_first, n_first, r_last, n_last;
    logic r_fa, n_fa, r_fb, n_fb, r_any, n_any, r_mvb2, n_mvb2;
    logic [CARD_W-1:0] r_n, n_n;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic r_done, n_done, r_found, n_found;
    logic [CARD_W-1:0] r_key, n_key;

    logic [IDX_W-1:0] raddr, waddr, src;
    logic we0, we1;
    logic [CARD_W-1:0] wdata, rd0, rd1, rd;
    logic rvalid;

    sol_ram #(.WIDTH(CARD_W), .DEPTH(N)) u_bank0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd0)
    );
    sol_ram #(.WIDTH(CARD_W), .DEPTH(N)) u_bank1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd1)
    );

    assign rd = r_bank ? rd1 : rd0;
    assign src = r_cnt[IDX_W-1:0] - 5'd1;
    assign rvalid = (r_cnt != '0);

    function automatic logic [IDX_W-1:0] mv_dst(input logic [IDX_W-1:0] s,
                                                input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] d;
        if (p != LAST) begin
            d = (s == p) ? p + 5'd1 : ((s == p + 5'd1) ? p : s);
        end else begin
            d = (s == LAST) ? 5'd1 : ((s >= 5'd1) ? s + 5'd1 : s);
        end
        return d;
    endfunction

    always_comb begin
        n_state = r_state; n_bank = r_bank; n_cnt = r_cnt;
        n_pa = r_pa; n_pb = r_pb; n_first = r_first; n_last = r_last;
        n_fa = r_fa; n_fb = r_fb; n_any = r_any; n_mvb2 = r_mvb2;
        n_n = r_n; n_steps = r_steps; n_done = 1'b0; n_found = r_found; n_key = r_key;
        raddr = r_cnt[IDX_W-1:0];
        if (r_cnt > 6'(LAST)) raddr = LAST;
        waddr = i_load_pos; wdata = i_load_card; we0 = 1'b0; we1 = 1'b0;
        case (r_state)
            S_INIT: begin
                waddr = r_cnt[IDX_W-1:0];
                wdata = reset_card(r_cnt[IDX_W-1:0]);
                we0 = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(LAST)) begin
                    n_state = S_IDLE; n_cnt = '0; n_bank = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_load && i_load_pos <= LAST) begin
                    we0 = ~r_bank; we1 = r_bank;
                end
                if (i_start) begin
                    n_state = S_SCANA; n_cnt = '0; n_fa = 1'b0; n_steps = '0;
                end
            end
            S_SCANA, S_SCANB, S_SCANJ: begin
                n_cnt = r_cnt + 6'd1;
                if (rvalid) begin
                    if (r_state == S_SCANA && rd == JOKER_A && !r_fa) begin
                        n_fa = 1'b1; n_pa = src;
                    end
                    if (r_state == S_SCANB && rd == JOKER_B && !r_fb) begin
                        n_fb = 1'b1; n_pb = src;
                    end
                    if (r_state == S_SCANJ && (rd == JOKER_A || rd == JOKER_B)) begin
                        if (!r_any) n_first = src;
                        n_last = src; n_any = 1'b1;
                    end
                end
                if (r_cnt == 6'(N)) begin
                    n_cnt = '0;
                    case (r_state)
                        S_SCANA: n_state = r_fa ? S_MOVA : S_SCANB;
                        S_SCANB: n_state = r_fb ? S_MOVB : S_SCANJ;
                        default: n_state = r_any ? S_TCUT : S_BOT;
                    endcase
                    if (r_state == S_SCANA) begin
                        n_fb = 1'b0; n_mvb2 = 1'b0;
                        if (r_fa) n_fa = 1'b1;
                    end
                    if (r_state == S_SCANB) n_any = 1'b0;
                    // last element still in flight
                    if (rvalid && r_state == S_SCANA && rd == JOKER_A && !r_fa) begin
                        n_state = S_MOVA;
                    end
                    if (rvalid && r_state == S_SCANB && rd == JOKER_B && !r_fb) begin
                        n_state = S_MOVB;
                    end
                    if (rvalid && r_state == S_SCANJ && (rd == JOKER_A || rd == JOKER_B)) begin
                        n_state = S_TCUT;
                    end
                end
            end
            S_MOVA, S_MOVB, S_TCUT, S_BOT, S_CCUT: begin
                n_cnt = r_cnt + 6'd1;
                if (r_state == S_BOT) begin
                    raddr = LAST;
                    if (r_cnt == 6'd1) begin
                        n_n = card_count(rd); n_cnt = '0; n_state = S_CCUT;
                    end
                end else if (rvalid) begin
                    we0 = r_bank; we1 = ~r_bank;
                    wdata = rd;
                    case (r_state)
                        S_MOVA: waddr = mv_dst(src, r_pa);
                        S_MOVB: waddr = mv_dst(src, r_pb);
                        S_TCUT: begin
                            if (src > r_last) waddr = src - r_last - 5'd1;
                            else if (src >= r_first) waddr = src + LAST - r_last - r_first;
                            else waddr = src + LAST + 5'd1 - r_first;
                        end
                        default: begin
                            if (src == LAST) waddr = LAST;
                            else if (src >= r_n) waddr = src - r_n;
                            else waddr = src + LAST - r_n;
                        end
                    endcase
                end
                if (r_state != S_BOT && r_cnt == 6'(N)) begin
                    n_cnt = '0; n_bank = ~r_bank;
                    case (r_state)
                        S_MOVA: n_state = S_SCANB;
                        S_MOVB: begin
                            if (!r_mvb2) begin
                                n_mvb2 = 1'b1;
                                n_pb = (r_pb == LAST) ? 5'd1 : r_pb + 5'd1;
                            end else begin
                                n_state = S_SCANJ;
                            end
                        end
                        S_TCUT: n_state = S_BOT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                // read top card, then the card at its count
                n_cnt = r_cnt + 6'd1;
                raddr = (r_cnt == 6'd0) ? 5'd0 : card_count(rd);
                if (r_cnt == 6'd2) begin
                    n_cnt = '0;
                    n_steps = r_steps + 8'd1;
                    if (rd >= 5'd1 && rd <= 5'(NUM_LETTERS)) begin
                        n_found = 1'b1; n_key = rd; n_done = 1'b1; n_state = S_IDLE;
                    end else if (r_steps == 8'(STEP_LIMIT - 1)) begin
                        n_found = 1'b0; n_done = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_state = S_SCANA; n_fa = 1'b0;
                    end
                end else if (r_cnt == 6'd1) begin
                    n_n = card_count(rd);
                end
                if (r_cnt == 6'd2) raddr = r_n;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_cnt <= '0; r_bank <= 1'b0; r_done <= 1'b0;
            r_found <= 1'b0; r_steps <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_bank <= n_bank; r_done <= n_done;
            r_found <= n_found; r_steps <= n_steps;
        end
        r_pa <= n_pa; r_pb <= n_pb; r_first <= n_first; r_last <= n_last;
        r_fa <= n_fa; r_fb <= n_fb; r_any <= n_any; r_mvb2 <= n_mvb2;
        r_n <= n_n; r_key <= n_key;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_found = r_found;
    assign o_key = r_key;
endmodule
`default_nettype wire

// ===== design/solitaire_keystream_cipher_top.sv =====
// solitaire keystream cipher top level: input handshake, letter shift, output register
// depends on sol_pkg, sol_keystep
// usage:
//  input channel i_valid/o_ready carries op, position, card, letter; output channel
//  o_valid/i_ready carries letter_out and key_value.
//  a load word writes one deck card and gives no result; op 3 is dropped.
//  an encrypt or decrypt word runs keystream steps until an ordinary output card shows,
//  at most 128 steps; if none shows, no result is given. a step is three scans, one copy
//  pass per joker move (three with both jokers present), a triple-cut pass when a joker
//  is present, a bottom read, a count-cut pass and an output read. o_valid rises from
//  the output register, which is loaded from the registered done of the last step.
//  the deck is held in two 28-entry memories used as ping-pong banks, one sweep per pass.
//  after reset the block writes the initial key order and holds o_ready low meanwhile.
//  a finished result waits in the output register with o_ready low; the next word is
//  accepted from the cycle after the result is taken.
`default_nettype none
module solitaire_keystream_cipher_top import sol_pkg::*; #(
    parameter int DECK_SIZE = 28
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_op,
    input  wire logic [IDX_W-1:0]    i_position,
    input  wire logic [CARD_W-1:0]   i_card,
    input  wire logic [CARD_W-1:0]   i_letter,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [CARD_W-1:0]        o_letter_out,
    output logic [CARD_W-1:0]        o_key_value
);
    logic busy, done, found, acc, is_ld, is_run;
    logic [CARD_W-1:0] key;
    logic r_pend, n_pend, r_dec, n_dec, r_ov, n_ov;
    logic [CARD_W-1:0] r_let, n_let, r_lo, n_lo, r_kv, n_kv;
    logic [5:0] sum;
    logic [5:0] sum_m;

    // pending result must be able to land: allow start only if output is free
    assign o_ready = !busy && !r_pend && !r_ov;
    assign acc = i_valid && o_ready;
    assign is_ld = acc && (t_op'(i_op) == OP_LOAD);
    assign is_run = acc && (t_op'(i_op) == OP_ENCRYPT || t_op'(i_op) == OP_DECRYPT);

    sol_keystep #(.N(DECK_SIZE)) u_step (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(is_run), .i_load(is_ld),
        .i_load_pos(i_position), .i_load_card(i_card),
        .o_busy(busy), .o_done(done), .o_found(found), .o_key(key)
    );

    // letter mod 26 first, then add or subtract key
    always_comb begin
        logic [CARD_W-1:0] lm;
        lm = (r_let >= 5'd26) ? r_let - 5'd26 : r_let;
        if (!r_dec) sum = 6'(lm) + 6'(key);
        else sum = 6'(lm) + 6'd26 - 6'(key);
        sum_m = (sum > 6'd26) ? sum - 6'd26 : sum;
        if (sum_m == 6'd0) sum_m = 6'd26;
    end

    always_comb begin
        n_pend = r_pend; n_dec = r_dec; n_let = r_let; n_ov = r_ov; n_lo = r_lo; n_kv = r_kv;
        if (is_run) begin
            n_pend = 1'b1; n_dec = (t_op'(i_op) == OP_DECRYPT); n_let = i_letter;
        end
        if (r_ov && i_ready) n_ov = 1'b0;
        if (done) begin
            n_pend = 1'b0;
            if (found) begin
                n_ov = 1'b1; n_lo = sum_m[CARD_W-1:0]; n_kv = key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_pend <= n_pend; r_ov <= n_ov;
        end
        r_dec <= n_dec; r_let <= n_let; r_lo <= n_lo; r_kv <= n_kv;
    end

    assign o_valid = r_ov;
    assign o_letter_out = r_lo;
    assign o_key_value = r_kv;
endmodule
`default_nettype wire

// ===== design/sol_checker.sv =====
// port-level checker for the solitaire keystream top, bound to it below
// depends on sol_pkg
`default_nettype none
module sol_checker import sol_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [CARD_W-1:0] o_letter_out,
    input wire logic [CARD_W-1:0] o_key_value
);
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_value >= 5'd1 && o_key_value <= 5'd26)) else $error("key range");
    a_let_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_letter_out >= 5'd1 && o_letter_out <= 5'd26)) else $error("letter range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_value) && $stable(o_letter_out))
        else $error("output dropped");
    a_no_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while output full");
endmodule

bind solitaire_keystream_cipher_top sol_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_letter_out(o_letter_out),
    .o_key_value(o_key_value)
);
`default_nettype wire
